// ===== design/priority_selection_sorter_defines.svh =====
// Assertion macros for the priority selection sorter.
// Used by the top level; expects clk and arst_n in scope.
`ifndef PRIORITY_SELECTION_SORTER_DEFINES_SVH
`define PRIORITY_SELECTION_SORTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PSS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pss assertion failed");

// next-cycle implication, checked out of reset
`define PSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pss assertion failed");

`endif

// ===== design/pss_pkg.sv =====
// Shared types and microcode ROM for the priority selection sorter.
// No dependencies; used by pss_seq and priority_selection_sorter.
`timescale 1ns / 1ps

package pss_pkg;

	localparam int HANDLE_W = 24;
	localparam int PRIO_W   = 8;

	typedef struct packed {
		logic [HANDLE_W-1:0] h;
		logic [PRIO_W-1:0]   p;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SORT_INIT,
		ST_PASS_RD,
		ST_PASS_LD,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_EMIT_INIT,
		ST_EMIT_RD,
		ST_EMIT_OUT,
		ST_DONE
	} step_t;

	typedef enum logic {RD_POS, RD_SCAN} rd_sel_t;
	typedef enum logic [1:0] {WR_NONE, WR_LOAD, WR_POS, WR_BEST} wr_sel_t;
	typedef enum logic [1:0] {POS_HOLD, POS_CLR, POS_INC} pos_op_t;
	typedef enum logic [1:0] {SCAN_HOLD, SCAN_LOAD, SCAN_INC} scan_op_t;
	typedef enum logic [1:0] {BEST_HOLD, BEST_INIT, BEST_CMP} best_op_t;
	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_WAIT,
		C_SHORT,
		C_SCAN_MORE,
		C_POS_MORE,
		C_EMIT_MORE
	} cond_t;

	// one control word per step
	typedef struct packed {
		rd_sel_t  rd_sel;
		wr_sel_t  wr_sel;
		pos_op_t  pos_op;
		scan_op_t scan_op;
		best_op_t best_op;
		logic     strobe;
		logic     clr_cnt;
		cond_t    cond;
		step_t    target;
	} ctrl_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic wait_hold;
		logic short_list;
		logic scan_more;
		logic pos_more;
		logic emit_more;
	} stat_t;

	localparam ctrl_t CTRL_NOP = '{
		rd_sel: RD_POS, wr_sel: WR_NONE, pos_op: POS_HOLD, scan_op: SCAN_HOLD,
		best_op: BEST_HOLD, strobe: 1'b0, clr_cnt: 1'b0, cond: C_NEXT, target: ST_IDLE
	};

	// Program: jump to target when cond holds, else fall through to step + 1.
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t c;
		c = CTRL_NOP;
		case (step)
			ST_IDLE: begin
				c.wr_sel = WR_LOAD;
				c.cond   = C_WAIT;
				c.target = ST_IDLE;
			end
			ST_SORT_INIT: begin
				c.pos_op = POS_CLR;
				c.cond   = C_SHORT;
				c.target = ST_EMIT_INIT;
			end
			ST_PASS_RD: begin
				c.rd_sel  = RD_POS;
				c.scan_op = SCAN_LOAD;
			end
			ST_PASS_LD: begin
				c.best_op = BEST_INIT;
			end
			ST_SCAN_RD: begin
				c.rd_sel = RD_SCAN;
			end
			ST_SCAN_CMP: begin
				c.best_op = BEST_CMP;
				c.scan_op = SCAN_INC;
				c.cond    = C_SCAN_MORE;
				c.target  = ST_SCAN_RD;
			end
			ST_SWAP_A: begin
				c.wr_sel = WR_POS;
			end
			ST_SWAP_B: begin
				c.wr_sel = WR_BEST;
				c.pos_op = POS_INC;
				c.cond   = C_POS_MORE;
				c.target = ST_PASS_RD;
			end
			ST_EMIT_INIT: begin
				c.pos_op = POS_CLR;
			end
			ST_EMIT_RD: begin
				c.rd_sel = RD_POS;
			end
			ST_EMIT_OUT: begin
				c.strobe = 1'b1;
				c.pos_op = POS_INC;
				c.cond   = C_EMIT_MORE;
				c.target = ST_EMIT_RD;
			end
			ST_DONE: begin
				c.clr_cnt = 1'b1;
				c.cond    = C_ALWAYS;
				c.target  = ST_IDLE;
			end
			default: begin
				c.cond   = C_ALWAYS;
				c.target = ST_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

// ===== design/pss_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on pss_pkg.
`timescale 1ns / 1ps

module pss_seq import pss_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl,
	output logic  busy
);

	step_t step_q;
	step_t step_d;
	logic  take;

	// next step
	always_comb begin
		case (ctrl.cond)
			C_NEXT:      take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_WAIT:      take = stat.wait_hold;
			C_SHORT:     take = stat.short_list;
			C_SCAN_MORE: take = stat.scan_more;
			C_POS_MORE:  take = stat.pos_more;
			C_EMIT_MORE: take = stat.emit_more;
			default:     take = 1'b1;
		endcase
		step_d = take ? ctrl.target : step_t'(step_q + 4'd1);
	end

	// control word out of the ROM
	always_comb begin
		ctrl = ucode(step_q);
		busy = (step_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

// ===== design/priority_selection_sorter.sv =====
// Priority selection sorter top level: entry memory, sort datapath, sequencer.
// Depends on pss_pkg, pss_seq and priority_selection_sorter_defines.svh.
//
//   channel | handshake        | payload
//   --------+------------------+-----------------------------------------
//   input   | start, busy      | handle, priority_req, is_last
//   result  | strobe           | out_handle, out_priority, out_last
//
// Loading accepts one transaction per cycle while busy is low.
// The closing transaction raises busy while the n entries are sorted and emitted:
// every compare and swap goes through the single read port of the entry memory.
// Each result needs a read step and a strobe step; busy drops after the DONE step.
// Reset clears the entry count and the step counter; the memory is not cleared.
// The receiver cannot stall: each result is valid for the single strobe cycle.
`timescale 1ns / 1ps
`include "priority_selection_sorter_defines.svh"

module priority_selection_sorter import pss_pkg::*; #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [PRIO_W-1:0]   priority_req,
	input  logic                is_last,
	output logic                strobe,
	output logic [HANDLE_W-1:0] out_handle,
	output logic [PRIO_W-1:0]   out_priority,
	output logic                out_last
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int EW = CW + 1;

	ctrl_t ctrl;
	stat_t stat;

	logic [CW-1:0] cnt_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] scan_q;
	logic [AW-1:0] best_idx_q;
	entry_t        best_q;
	entry_t        pos_ent_q;
	entry_t        rd_q;
	entry_t        mem [MAX_ENTRIES];

	logic          accept;
	logic          room;
	logic          load_we;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	logic [AW-1:0] rd_addr;
	logic          emit_last;

	pss_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	assign accept  = start & ~busy;
	assign room    = (cnt_q < CW'(MAX_ENTRIES));
	assign load_we = (ctrl.wr_sel == WR_LOAD) & accept & room;

	assign emit_last = ((EW'(pos_q) + EW'(1)) == EW'(cnt_q));

	always_comb begin
		stat.wait_hold  = ~(accept & is_last);
		stat.short_list = (cnt_q < CW'(2));
		stat.scan_more  = ((EW'(scan_q) + EW'(1)) < EW'(cnt_q));
		stat.pos_more   = ((EW'(pos_q) + EW'(2)) < EW'(cnt_q));
		stat.emit_more  = ~emit_last;
	end

	// memory port selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = best_q;
		case (ctrl.wr_sel)
			WR_LOAD: begin
				wr_en   = load_we;
				wr_addr = cnt_q[AW-1:0];
				wr_data = '{h: handle, p: priority_req};
			end
			WR_POS: begin
				wr_en   = 1'b1;
				wr_addr = pos_q;
				wr_data = best_q;
			end
			WR_BEST: begin
				wr_en   = 1'b1;
				wr_addr = best_idx_q;
				wr_data = pos_ent_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
		rd_addr = (ctrl.rd_sel == RD_SCAN) ? scan_q : pos_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.clr_cnt) begin
			cnt_q <= '0;
		end else if (load_we) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.pos_op)
			POS_CLR:  pos_q <= '0;
			POS_INC:  pos_q <= pos_q + AW'(1);
			default:  pos_q <= pos_q;
		endcase
		case (ctrl.scan_op)
			SCAN_LOAD: scan_q <= pos_q + AW'(1);
			SCAN_INC:  scan_q <= scan_q + AW'(1);
			default:   scan_q <= scan_q;
		endcase
		// strictly smaller keeps the first minimum
		case (ctrl.best_op)
			BEST_INIT: begin
				best_idx_q <= pos_q;
				best_q     <= rd_q;
				pos_ent_q  <= rd_q;
			end
			BEST_CMP: begin
				if (rd_q.p < best_q.p) begin
					best_idx_q <= scan_q;
					best_q     <= rd_q;
				end
			end
			default: begin
				best_q <= best_q;
			end
		endcase
	end

	assign strobe       = ctrl.strobe;
	assign out_handle   = rd_q.h;
	assign out_priority = rd_q.p;
	assign out_last     = emit_last;

	`PSS_ASSERT_NOW(a_strobe_busy, strobe, busy)
	`PSS_ASSERT_NEXT(a_last_quiet, strobe && out_last, !strobe)
	`PSS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(MAX_ENTRIES))
	`PSS_ASSERT_NEXT(a_close_busy, accept && is_last, busy)

endmodule
